// ===== sv/authenticated_datagram_checker_defines.svh =====
// Assertion macros shared by the authenticated datagram checker modules.
`ifndef AUTHENTICATED_DATAGRAM_CHECKER_DEFINES_SVH
`define AUTHENTICATED_DATAGRAM_CHECKER_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define ADC_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after the condition.
`define ADC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/adc_pkg.sv =====
// Types, constants and tables shared by the authenticated datagram checker.
`default_nettype none

package adc_pkg;

    localparam int ADC_MAX_DATAGRAM_BYTES = 2048;
    localparam int PREFIX_BYTES = 44;
    localparam int DIGEST_BYTES = 32;
    localparam int FULL_HEADER = PREFIX_BYTES + DIGEST_BYTES;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [11:0] COUNT_CAP = 12'hFFF;
    localparam logic [11:0] PAYLOAD_CAP = 12'd2048;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED    = 3'd0,
        VERDICT_MALFORMED   = 3'd1,
        VERDICT_BAD_VERSION = 3'd2,
        VERDICT_DIGEST      = 3'd3,
        VERDICT_STALE       = 3'd4,
        VERDICT_REPLAY      = 3'd5,
        VERDICT_TOO_LARGE   = 3'd6
    } adc_verdict_t;

    typedef enum logic [1:0] {
        CFG_MAGIC     = 2'd0,
        CFG_VERSION   = 2'd1,
        CFG_MAX_BYTES = 2'd2
    } adc_cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } adc_in_t;

    typedef struct packed {
        adc_verdict_t verdict;
        logic [15:0]  msg_kind;
        logic [63:0]  epoch_value;
        logic [63:0]  sequence_number;
        logic [63:0]  channel_number;
        logic [63:0]  frame_number;
        logic [11:0]  payload_length;
    } adc_out_t;

    // One entry of the queue between parser and hash engine.
    typedef struct packed {
        logic         fin;
        logic         need_hash;
        logic         two_blk;
        logic [11:0]  msg_len;
        logic [511:0] blk;
        logic [255:0] digest;
        adc_out_t     res;
    } adc_job_t;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

`default_nettype wire

// ===== sv/authenticated_datagram_checker.sv =====
// Top level of the authenticated datagram checker.
// Usage: bytes of a datagram arrive on the byte channel, one word per byte, with
// last_byte set on the final byte. One word leaves on the verdict channel per
// datagram, carrying the verdict and the prefix fields. The cfg channel writes
// the magic, version and size limit registers; it is always ready.
// The parser takes one byte per cycle while byte_ready is high; it pauses
// after every 64 hashed bytes and after the final byte until the queue takes
// the job. The hash engine works each 64-byte block as a load, 64 rounds and a
// final add, and takes no new job until it is back in idle. A verdict waits
// behind any blocks still queued, and a second padding block runs the rounds
// again; rejected datagrams that need no digest skip the rounds and go straight
// to the output register.
// Reset clears the byte counters and the replay window, loads the initial hash
// value, and sets the registers to magic 0, version 1 and limit 2048.
// When the receiver stalls, the finished verdict waits in the output register,
// the engine waits, the two-entry job queue fills and then byte_ready drops.
`default_nettype none

module authenticated_datagram_checker
    import adc_pkg::*;
#(
    parameter int MAX_DATAGRAM_BYTES = ADC_MAX_DATAGRAM_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  adc_in_t     byte_data,
    output logic        verdict_valid,
    input  logic        verdict_ready,
    output adc_out_t    verdict_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic     push_valid, push_ready, pop_valid, pop_ready;
    adc_job_t push_job, pop_job;

    adc_front #(
        .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    adc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    adc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (pop_valid),
        .job_ready     (pop_ready),
        .job           (pop_job),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_data  (verdict_data)
    );

endmodule

`default_nettype wire

// ===== sv/adc_front.sv =====
// Front end: configuration registers, byte parser and block assembly.
`default_nettype none
`include "authenticated_datagram_checker_defines.svh"

module adc_front
    import adc_pkg::*;
#(
    parameter int MAX_DATAGRAM_BYTES = ADC_MAX_DATAGRAM_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  adc_in_t     byte_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        push_valid,
    input  logic        push_ready,
    output adc_job_t    push_job
);

    localparam int LIM_W = ($clog2(MAX_DATAGRAM_BYTES + 1) > 12) ?
                           $clog2(MAX_DATAGRAM_BYTES + 1) : 12;

    logic [31:0] magic_reg;
    logic [15:0] version_reg;
    logic [11:0] max_reg;

    logic [11:0] cnt_reg, cnt_next;
    logic        too_long_reg, too_long_next;
    logic [11:0] msg_reg, msg_next;
    logic        blk_pend_reg, blk_pend_next;
    logic        fin_pend_reg, fin_pend_next;
    logic [63:0] hdr_reg [6];
    logic [63:0] hdr_next [6];
    logic [63:0] dig_reg [4];
    logic [63:0] dig_next [4];
    logic [0:63][7:0] buf_reg, buf_next;

    logic        byte_fire, push_fire, over, hash_en;
    logic [2:0]  hdr_idx;
    logic [5:0]  dig_off;
    logic [5:0]  pos;
    logic        two;
    logic [0:63][7:0] padded;
    logic [63:0] len_bits;
    logic [31:0] declared;
    logic        need_hash;
    adc_out_t    final_res;

    assign cfg_ready  = 1'b1;
    assign byte_ready = !blk_pend_reg && !fin_pend_reg;
    assign byte_fire  = byte_valid && byte_ready;
    assign push_valid = blk_pend_reg || fin_pend_reg;
    assign push_fire  = push_valid && push_ready;

    // The limit in use is the smaller of the register and the parameter.
    assign over = (LIM_W'(cnt_reg) >= LIM_W'(MAX_DATAGRAM_BYTES)) || (cnt_reg >= max_reg);
    assign hdr_idx = cnt_reg[5:3];
    assign dig_off = 6'(cnt_reg - 12'(PREFIX_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= '0;
            version_reg <= 16'd1;
            max_reg     <= 12'd2048;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAGIC:     magic_reg   <= cfg_data;
                CFG_VERSION:   version_reg <= cfg_data[15:0];
                CFG_MAX_BYTES: max_reg     <= cfg_data[11:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        too_long_next = too_long_reg;
        msg_next      = msg_reg;
        blk_pend_next = blk_pend_reg;
        fin_pend_next = fin_pend_reg;
        hdr_next      = hdr_reg;
        dig_next      = dig_reg;
        buf_next      = buf_reg;
        hash_en       = 1'b0;
        if (byte_fire)
        begin
            if (over)
            begin
                too_long_next = 1'b1;
            end
            else
            begin
                if (cnt_reg < 12'(PREFIX_BYTES))
                begin
                    hdr_next[hdr_idx] = {hdr_reg[hdr_idx][55:0], byte_data.data_byte};
                    hash_en = 1'b1;
                end
                else if (cnt_reg < 12'(FULL_HEADER))
                begin
                    dig_next[dig_off[4:3]] = {dig_reg[dig_off[4:3]][55:0], byte_data.data_byte};
                end
                else
                begin
                    hash_en = 1'b1;
                end
                if (cnt_reg != COUNT_CAP)
                begin
                    cnt_next = cnt_reg + 12'd1;
                end
            end
            if (hash_en)
            begin
                buf_next[msg_reg[5:0]] = byte_data.data_byte;
                msg_next = msg_reg + 12'd1;
                if (msg_reg[5:0] == 6'd63)
                begin
                    blk_pend_next = 1'b1;
                end
            end
            if (byte_data.last_byte)
            begin
                fin_pend_next = 1'b1;
            end
        end
        if (push_fire)
        begin
            if (blk_pend_reg)
            begin
                blk_pend_next = 1'b0;
            end
            else
            begin
                fin_pend_next = 1'b0;
                cnt_next      = '0;
                too_long_next = 1'b0;
                msg_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            too_long_reg <= 1'b0;
            msg_reg      <= '0;
            blk_pend_reg <= 1'b0;
            fin_pend_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            too_long_reg <= too_long_next;
            msg_reg      <= msg_next;
            blk_pend_reg <= blk_pend_next;
            fin_pend_reg <= fin_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        dig_reg <= dig_next;
        buf_reg <= buf_next;
    end

    // Padding of the last block; the length goes into a second block when
    // eight or fewer bytes of the block remain.
    assign pos      = msg_reg[5:0];
    assign two      = (pos >= 6'd56);
    assign len_bits = {49'd0, msg_reg, 3'd0};

    always_comb
    begin
        for (int p = 0; p < 64; p++)
        begin
            if (6'(p) < pos)
            begin
                padded[p] = buf_reg[p];
            end
            else if (6'(p) == pos)
            begin
                padded[p] = 8'h80;
            end
            else
            begin
                padded[p] = 8'h00;
            end
        end
        if (!two)
        begin
            for (int j = 0; j < 8; j++)
            begin
                padded[56 + j] = len_bits[63 - 8 * j -: 8];
            end
        end
    end

    assign declared = hdr_reg[5][31:0];

    always_comb
    begin
        final_res = '0;
        need_hash = 1'b0;
        if (too_long_reg)
        begin
            final_res.verdict = VERDICT_TOO_LARGE;
        end
        else if (cnt_reg < 12'(FULL_HEADER))
        begin
            final_res.verdict = VERDICT_MALFORMED;
        end
        else
        begin
            final_res.msg_kind        = hdr_reg[0][15:0];
            final_res.epoch_value     = hdr_reg[1];
            final_res.sequence_number = hdr_reg[2];
            final_res.channel_number  = hdr_reg[3];
            final_res.frame_number    = hdr_reg[4];
            final_res.payload_length  = (declared > 32'd2048) ? PAYLOAD_CAP : declared[11:0];
            if (hdr_reg[0][63:32] != magic_reg)
            begin
                final_res.verdict = VERDICT_MALFORMED;
            end
            else if (hdr_reg[0][31:16] != version_reg)
            begin
                final_res.verdict = VERDICT_BAD_VERSION;
            end
            else if (declared != {20'd0, 12'(cnt_reg - 12'(FULL_HEADER))})
            begin
                final_res.verdict = VERDICT_MALFORMED;
            end
            else
            begin
                final_res.verdict = VERDICT_ACCEPTED;
                need_hash = 1'b1;
            end
        end
    end

    always_comb
    begin
        push_job.fin       = !blk_pend_reg;
        push_job.need_hash = need_hash;
        push_job.two_blk   = two;
        push_job.msg_len   = msg_reg;
        push_job.blk       = blk_pend_reg ? buf_reg : padded;
        push_job.digest    = {dig_reg[0], dig_reg[1], dig_reg[2], dig_reg[3]};
        push_job.res       = final_res;
    end

    `ADC_ASSERT_IMP(a_block_aligned, clk, rst_n, blk_pend_reg, msg_reg[5:0] == 6'd0, "full block not aligned")
    `ADC_ASSERT_NEXT(a_end_clears, clk, rst_n, push_fire && !blk_pend_reg, (cnt_reg == 12'd0) && (msg_reg == 12'd0) && !too_long_reg, "datagram state not cleared")
    `ADC_ASSERT_IMP(a_hashed_le_count, clk, rst_n, 1'b1, msg_reg <= cnt_reg, "hashed bytes exceed counted bytes")

endmodule

`default_nettype wire

// ===== sv/adc_queue.sv =====
// Short queue of hash jobs between the parser and the hash engine.
`default_nettype none

module adc_queue
    import adc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  adc_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output adc_job_t pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    adc_job_t         q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push_fire, pop_fire;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = q_reg[rd_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
            end
            if (pop_fire)
            begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
            end
            if (push_fire && !pop_fire)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop_fire && !push_fire)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            q_reg[wr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/adc_back.sv =====
// Back end: SHA-256 compression engine, digest check and replay window.
`default_nettype none
`include "authenticated_datagram_checker_defines.svh"

module adc_back
    import adc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  adc_job_t job,
    output logic     verdict_valid,
    input  logic     verdict_ready,
    output adc_out_t verdict_data
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } adc_state_t;

    adc_state_t   state_reg, state_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  h_next [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [5:0]   rnd_reg, rnd_next;
    logic         fin_reg, fin_next;
    logic         second_reg, second_next;
    logic [11:0]  len_reg, len_next;
    logic [255:0] digest_reg, digest_next;
    adc_out_t     res_reg, res_next;
    logic [63:0]  epoch_reg, epoch_next;
    logic [63:0]  hiseq_reg, hiseq_next;
    logic         out_valid_reg, out_valid_next;
    adc_out_t     out_data_reg, out_data_next;

    logic [31:0]  hsum [8];
    logic [31:0]  t1, t2, new_w;
    logic         digest_ok, out_load;
    logic [63:0]  hs_eff;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign job_ready     = (state_reg == ST_IDLE);
    assign verdict_valid = out_valid_reg;
    assign verdict_data  = out_data_reg;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || verdict_ready);

    always_comb
    begin
        t1 = v_reg[7]
           + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + SHA_K[rnd_reg] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        new_w = w_reg[0]
              + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + w_reg[9]
              + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
        for (int i = 0; i < 8; i++)
        begin
            hsum[i] = h_reg[i] + v_reg[i];
        end
        digest_ok = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            if (digest_reg[255 - 32 * k -: 32] != h_reg[k])
            begin
                digest_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        rnd_next       = rnd_reg;
        fin_next       = fin_reg;
        second_next    = second_reg;
        len_next       = len_reg;
        digest_next    = digest_reg;
        res_next       = res_reg;
        epoch_next     = epoch_reg;
        hiseq_next     = hiseq_reg;
        out_valid_next = out_valid_reg && !verdict_ready;
        out_data_next  = out_data_reg;
        hs_eff         = hiseq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    fin_next    = job.fin;
                    second_next = job.fin && job.two_blk;
                    len_next    = job.msg_len;
                    digest_next = job.digest;
                    res_next    = job.res;
                    if (!job.fin || job.need_hash)
                    begin
                        v_next = h_reg;
                        for (int i = 0; i < 16; i++)
                        begin
                            w_next[i] = job.blk[511 - 32 * i -: 32];
                        end
                        rnd_next   = '0;
                        state_next = ST_ROUND;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ROUND:
            begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = new_w;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                h_next = hsum;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (second_reg)
                begin
                    // Extra padding block: zeros and the bit length.
                    v_next = hsum;
                    for (int i = 0; i < 16; i++)
                    begin
                        w_next[i] = '0;
                    end
                    w_next[15]  = {17'd0, len_reg, 3'd0};
                    rnd_next    = '0;
                    second_next = 1'b0;
                    state_next  = ST_ROUND;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!digest_ok)
                begin
                    res_next.verdict = VERDICT_DIGEST;
                end
                else if (res_reg.epoch_value < epoch_reg)
                begin
                    res_next.verdict = VERDICT_STALE;
                end
                else
                begin
                    // A newer epoch restarts the sequence window.
                    hs_eff     = (res_reg.epoch_value > epoch_reg) ? 64'd0 : hiseq_reg;
                    epoch_next = res_reg.epoch_value;
                    if ((res_reg.sequence_number == 64'd0) ||
                        (res_reg.sequence_number <= hs_eff))
                    begin
                        res_next.verdict = VERDICT_REPLAY;
                        hiseq_next = hs_eff;
                    end
                    else
                    begin
                        res_next.verdict = VERDICT_ACCEPTED;
                        hiseq_next = res_reg.sequence_number;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    h_next         = SHA_H0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            h_reg         <= SHA_H0;
            rnd_reg       <= '0;
            fin_reg       <= 1'b0;
            second_reg    <= 1'b0;
            epoch_reg     <= '0;
            hiseq_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            rnd_reg       <= rnd_next;
            fin_reg       <= fin_next;
            second_reg    <= second_next;
            epoch_reg     <= epoch_next;
            hiseq_reg     <= hiseq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        w_reg        <= w_next;
        len_reg      <= len_next;
        digest_reg   <= digest_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    `ADC_ASSERT_NEXT(a_rounds_end, clk, rst_n, (state_reg == ST_ROUND) && (rnd_reg == 6'd63), state_reg == ST_ADD, "round count did not end in add")
    `ADC_ASSERT_IMP(a_second_is_final, clk, rst_n, second_reg, fin_reg, "padding block pending outside a final job")
    `ADC_ASSERT_IMP(a_accept_sets_seq, clk, rst_n, out_load && (res_reg.verdict == VERDICT_ACCEPTED), hiseq_reg != 64'd0, "accepted word left sequence window empty")

endmodule

`default_nettype wire

// ===== dv/authenticated_datagram_checker_test.sv =====
// Self-checking testbench for the authenticated datagram checker: datagram traffic with a local predictor.
`default_nettype none

module authenticated_datagram_checker_test;
    import adc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    adc_in_t     byte_data;
    logic        verdict_valid;
    logic        verdict_ready;
    adc_out_t    verdict_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    authenticated_datagram_checker u_dut (
        .clk(clk), .rst_n(rst_n),
        .byte_valid(byte_valid), .byte_ready(byte_ready), .byte_data(byte_data),
        .verdict_valid(verdict_valid), .verdict_ready(verdict_ready),
        .verdict_data(verdict_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Predictor state.
    logic [31:0] pr_magic;
    logic [15:0] pr_version;
    logic [11:0] pr_max_bytes;
    logic [11:0] pr_count;
    logic        pr_overflow;
    logic [63:0] pr_header [6];
    logic [63:0] pr_digest [4];
    logic [7:0]  pr_hashed [$];
    logic [63:0] pr_epoch;
    logic [63:0] pr_high_seq;

    adc_out_t verdict_queue [$];
    int       failures;
    int       bytes_sent;
    int       idle_cycles;
    int       burst_left;
    int       holdoff_req;

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] sha_block(logic [255:0] st, logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        logic [255:0] res;
        for (int i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = st[255 - 32 * i -: 32];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            res[255 - 32 * i -: 32] = st[255 - 32 * i -: 32] + v[i];
        return res;
    endfunction

    function automatic logic [255:0] digest_of(logic [7:0] msg [$]);
        logic [7:0]   padded [$];
        logic [63:0]  bits;
        logic [255:0] st;
        logic [511:0] blk;
        padded = msg;
        bits = 64'(msg.size()) << 3;
        padded.insert(padded.size(), 8'h80);
        while ((padded.size() % 64) != 56)
            padded.insert(padded.size(), 8'h00);
        for (int i = 7; i >= 0; i--)
            padded.insert(padded.size(), bits[8 * i +: 8]);
        for (int i = 0; i < 8; i++)
            st[255 - 32 * i -: 32] = SHA_H0[i];
        for (int b = 0; b < padded.size() / 64; b++)
        begin
            for (int i = 0; i < 64; i++)
                blk[511 - 8 * i -: 8] = padded[64 * b + i];
            st = sha_block(st, blk);
        end
        return st;
    endfunction

    task automatic absorb_byte(logic [7:0] b, logic last);
        logic [11:0]  lim;
        logic [11:0]  c;
        logic [31:0]  declared;
        logic [255:0] carried;
        adc_out_t     res;
        lim = (pr_max_bytes > 12'd2048) ? 12'd2048 : pr_max_bytes;
        if (pr_count >= lim)
            pr_overflow = 1'b1;
        else
        begin
            c = pr_count;
            if (c < PREFIX_BYTES)
            begin
                if ((c >> 3) < 6)
                    pr_header[c >> 3] = {pr_header[c >> 3][55:0], b};
                pr_hashed.insert(pr_hashed.size(), b);
            end
            else if (c < FULL_HEADER)
                pr_digest[(c - PREFIX_BYTES) >> 3] = {pr_digest[(c - PREFIX_BYTES) >> 3][55:0], b};
            else
                pr_hashed.insert(pr_hashed.size(), b);
            if (pr_count < COUNT_CAP)
                pr_count++;
        end
        if (!last)
            return;
        res = '0;
        if (pr_overflow)
            res.verdict = VERDICT_TOO_LARGE;
        else if (pr_count < FULL_HEADER)
            res.verdict = VERDICT_MALFORMED;
        else
        begin
            declared = pr_header[5][31:0];
            res.msg_kind = pr_header[0][15:0];
            res.epoch_value = pr_header[1];
            res.sequence_number = pr_header[2];
            res.channel_number = pr_header[3];
            res.frame_number = pr_header[4];
            res.payload_length = (declared > 32'd2048) ? PAYLOAD_CAP : declared[11:0];
            carried = {pr_digest[0], pr_digest[1], pr_digest[2], pr_digest[3]};
            if (pr_header[0][63:32] != pr_magic)
                res.verdict = VERDICT_MALFORMED;
            else if (pr_header[0][31:16] != pr_version)
                res.verdict = VERDICT_BAD_VERSION;
            else if (declared != 32'(pr_count - FULL_HEADER))
                res.verdict = VERDICT_MALFORMED;
            else if (digest_of(pr_hashed) != carried)
                res.verdict = VERDICT_DIGEST;
            else if (pr_header[1] < pr_epoch)
                res.verdict = VERDICT_STALE;
            else
            begin
                if (pr_header[1] > pr_epoch)
                begin
                    pr_epoch = pr_header[1];
                    pr_high_seq = '0;
                end
                if (pr_header[2] == 0 || pr_header[2] <= pr_high_seq)
                    res.verdict = VERDICT_REPLAY;
                else
                begin
                    pr_high_seq = pr_header[2];
                    res.verdict = VERDICT_ACCEPTED;
                end
            end
        end
        verdict_queue.insert(verdict_queue.size(), res);
        pr_count = '0;
        pr_overflow = 1'b0;
        pr_hashed.delete();
    endtask

    // Sender: bursts of random length separated by idle gaps of random length.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        if (burst_left <= 0)
        begin
            byte_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
        end
        byte_valid <= 1'b1;
        byte_data <= '{data_byte: b, last_byte: last};
        do
            @(posedge clk);
        while (!byte_ready);
        absorb_byte(b, last);
        bytes_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_frame(logic [7:0] frame [$]);
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    task automatic make_frame(output logic [7:0] frame [$], input logic [31:0] magic,
                              input logic [15:0] version, input logic [15:0] kind,
                              input logic [63:0] epoch, input logic [63:0] seq,
                              input logic [63:0] chan, input logic [63:0] frm,
                              input int pay_len, input int len_skew, input bit bad_digest);
        logic [351:0] prefix;
        logic [7:0]   hashed [$];
        logic [7:0]   payload [$];
        logic [255:0] dg;
        prefix = {magic, version, kind, epoch, seq, chan, frm, 32'(pay_len + len_skew)};
        for (int i = 0; i < PREFIX_BYTES; i++)
            hashed.insert(hashed.size(), prefix[351 - 8 * i -: 8]);
        for (int i = 0; i < pay_len; i++)
            payload.insert(payload.size(), 8'($urandom));
        dg = digest_of({hashed, payload});
        if (bad_digest)
            dg[$urandom_range(0, 255)] ^= 1'b1;
        frame = hashed;
        for (int i = 0; i < 32; i++)
            frame.insert(frame.size(), dg[255 - 8 * i -: 8]);
        frame = {frame, payload};
    endtask

    task automatic send_good(logic [63:0] epoch, logic [63:0] seq, int pay_len);
        logic [7:0] frame [$];
        make_frame(frame, pr_magic, pr_version, 16'($urandom), epoch, seq,
                   {$urandom, $urandom}, {$urandom, $urandom}, pay_len, 0, 1'b0);
        send_frame(frame);
    endtask

    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (verdict_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(adc_cfg_index_t idx, logic [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MAGIC:     pr_magic = value;
            CFG_VERSION:   pr_version = value[15:0];
            CFG_MAX_BYTES: pr_max_bytes = value[11:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_checks();
        logic [7:0] frame [$];
        send_byte(8'h00, 1'b1);
        send_frame('{8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55});
        send_good(64'd0, 64'd1, 0);
        send_good(64'd0, 64'd1, 3);
        send_good(64'd0, 64'd0, 1);
        send_good(64'd5, 64'd2, 5);
        send_good(64'd4, 64'd9, 2);
        make_frame(frame, pr_magic, 16'd2, 16'hFFFF, 64'd5, 64'd3, '1, '1, 4, 0, 1'b0);
        send_frame(frame);
        make_frame(frame, 32'hDEADBEEF, pr_version, 16'h0, 64'd5, 64'd3, '0, '0, 4, 0, 1'b0);
        send_frame(frame);
        make_frame(frame, pr_magic, pr_version, 16'h1, 64'd5, 64'd3, '0, '1, 4, 1, 1'b0);
        send_frame(frame);
        make_frame(frame, pr_magic, pr_version, 16'h2, 64'd5, 64'd3, '1, '0, 0, -1, 1'b0);
        send_frame(frame);
        make_frame(frame, pr_magic, pr_version, 16'h3, 64'd5, 64'd3, '0, '0, 0,
                   32'hFFFFFFFF, 1'b0);
        send_frame(frame);
        make_frame(frame, pr_magic, pr_version, 16'h4, 64'd5, 64'd3, '0, '0, 6, 0, 1'b1);
        send_frame(frame);
        send_good('1, '1, 1);
        send_good('1, '1, 0);
    endtask

    task automatic test_size_limit();
        write_reg(CFG_MAX_BYTES, 32'd76);
        send_good(pr_epoch, pr_high_seq + 1, 0);
        send_good(pr_epoch, pr_high_seq + 1, 1);
        send_good(pr_epoch, pr_high_seq + 1, 10);
        write_reg(CFG_MAX_BYTES, 32'd2048);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_MAGIC, 32'hFFFFFFFF);
        write_reg(CFG_VERSION, 32'h0000FFFF);
        send_good(pr_epoch + 1, 64'd1, 2);
        write_reg(CFG_VERSION, 32'h0);
        send_good(pr_epoch, 64'd2, 2);
        write_reg(CFG_MAGIC, 32'h0);
        send_good(pr_epoch, 64'd3, 2);
    endtask

    task automatic random_datagram();
        logic [7:0]  frame [$];
        logic [63:0] ep;
        logic [63:0] sq;
        int          pick;
        int          n;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // Noise: random bytes, usually short or with a foreign magic.
            n = $urandom_range(1, 100);
            for (int i = 0; i < n; i++)
                frame.insert(frame.size(), 8'($urandom));
            send_frame(frame);
            return;
        end
        case ($urandom_range(0, 3))
            0:       ep = pr_epoch + 1;
            1:       ep = (pr_epoch == 0) ? 64'd0 : pr_epoch - 1;
            default: ep = pr_epoch;
        endcase
        case ($urandom_range(0, 5))
            0:       sq = 64'd0;
            1:       sq = pr_high_seq;
            2:       sq = {$urandom, $urandom};
            default: sq = pr_high_seq + $urandom_range(1, 3);
        endcase
        n = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 300) : $urandom_range(0, 30);
        make_frame(frame,
                   ($urandom_range(0, 19) == 0) ? 32'($urandom) : pr_magic,
                   ($urandom_range(0, 19) == 0) ? 16'($urandom) : pr_version,
                   16'($urandom), ep, sq, {$urandom, $urandom}, {$urandom, $urandom}, n,
                   ($urandom_range(0, 19) == 0) ? $urandom_range(1, 3) : 0,
                   $urandom_range(0, 9) == 0);
        send_frame(frame);
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent < 1950)
        begin
            if (bytes_sent - start_bytes > 150 && pr_max_bytes == 12'd2048)
            begin
                write_reg(CFG_MAGIC, $urandom);
                write_reg(CFG_VERSION, $urandom);
                write_reg(CFG_MAX_BYTES, $urandom_range(76, 200));
            end
            random_datagram();
        end
    endtask

    task automatic test_backpressure();
        holdoff_req = 3000;
        send_good(pr_epoch, pr_high_seq + 1, 24);
        repeat (7) send_byte(8'h00, 1'b1);
    endtask

    // Receiver: a stall pattern of its own, plus a long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n)
            verdict_ready <= 1'b0;
        else if (holdoff_req > 0)
        begin
            verdict_ready <= 1'b0;
            holdoff_req <= holdoff_req - 1;
        end
        else if (($time / 2000) % 3 == 0)
            verdict_ready <= 1'b1;
        else
            verdict_ready <= $urandom_range(0, 2) != 0;
    end

    always @(posedge clk)
    begin
        if (verdict_valid && verdict_ready)
        begin
            if (verdict_queue.size() == 0)
            begin
                $display("%0t: verdict with none expected: actual %p", $time, verdict_data);
                failures++;
            end
            else
            begin
                adc_out_t want;
                want = verdict_queue[0];
                verdict_queue.delete(0);
                if (verdict_data.verdict !== want.verdict)
                    $display("%0t: verdict expected %0d actual %0d", $time,
                             want.verdict, verdict_data.verdict);
                if (verdict_data.msg_kind !== want.msg_kind)
                    $display("%0t: msg_kind expected %h actual %h", $time,
                             want.msg_kind, verdict_data.msg_kind);
                if (verdict_data.epoch_value !== want.epoch_value)
                    $display("%0t: epoch_value expected %h actual %h", $time,
                             want.epoch_value, verdict_data.epoch_value);
                if (verdict_data.sequence_number !== want.sequence_number)
                    $display("%0t: sequence_number expected %h actual %h", $time,
                             want.sequence_number, verdict_data.sequence_number);
                if (verdict_data.channel_number !== want.channel_number)
                    $display("%0t: channel_number expected %h actual %h", $time,
                             want.channel_number, verdict_data.channel_number);
                if (verdict_data.frame_number !== want.frame_number)
                    $display("%0t: frame_number expected %h actual %h", $time,
                             want.frame_number, verdict_data.frame_number);
                if (verdict_data.payload_length !== want.payload_length)
                    $display("%0t: payload_length expected %0d actual %0d", $time,
                             want.payload_length, verdict_data.payload_length);
                if (verdict_data !== want)
                    failures++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (verdict_valid && verdict_ready)
            || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        failures = 0;
        bytes_sent = 0;
        idle_cycles = 0;
        burst_left = 0;
        holdoff_req = 0;
        pr_magic = '0;
        pr_version = 16'd1;
        pr_max_bytes = 12'd2048;
        pr_count = '0;
        pr_overflow = 1'b0;
        pr_epoch = '0;
        pr_high_seq = '0;
        for (int i = 0; i < 6; i++)
            pr_header[i] = '0;
        for (int i = 0; i < 4; i++)
            pr_digest[i] = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_default_checks();
        test_size_limit();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
